// File: design/su3r_pkg.sv
// ============================================================================
// su3r_pkg
// Shared widths, types and fixed-point helpers for the SU(3) reunitarisation
// pipeline.
// ============================================================================
`timescale 1ns / 1ps

package su3r_pkg;

  localparam int WORD_BITS     = 32;
  localparam int FRACTION_BITS = 28;
  localparam int PARTS         = 6;
  localparam int ROWS          = 3;

  localparam int SUM_BITS  = 2 * WORD_BITS + 3;
  localparam int ROOT_BITS = (SUM_BITS + 1) / 2;
  localparam int RAD_BITS  = 2 * ROOT_BITS;
  localparam int REM_BITS  = ROOT_BITS + 3;
  localparam int NUM_BITS  = WORD_BITS + FRACTION_BITS + 1;
  localparam int DEN_BITS  = ROOT_BITS + 1;
  localparam int QUO_BITS  = FRACTION_BITS + 2;
  localparam int ACC_BITS  = ((2 * WORD_BITS > WORD_BITS + FRACTION_BITS) ?
                              2 * WORD_BITS : WORD_BITS + FRACTION_BITS) + 4;
  localparam int NORM_LAT  = ROOT_BITS + QUO_BITS + 4;

  typedef logic signed [WORD_BITS-1:0]   word_t;
  typedef word_t                         col_t [PARTS];
  typedef logic signed [2*WORD_BITS-1:0] prod_t;
  typedef logic signed [ACC_BITS-1:0]    acc_t;
  typedef logic [SUM_BITS-1:0]           sum_t;
  typedef logic [ROOT_BITS-1:0]          root_t;
  typedef logic [NUM_BITS-1:0]           num_t;
  typedef logic [DEN_BITS-1:0]           den_t;
  typedef logic [QUO_BITS-1:0]           quo_t;

  typedef struct packed {
    logic valid;
    logic zero;
  } norm_flags_t;

  typedef enum logic [1:0] {
    COL_U = 2'd0,
    COL_V = 2'd1,
    COL_W = 2'd2
  } col_idx_t;

  localparam int CROSS_A [ROWS] = '{1, 2, 0};
  localparam int CROSS_B [ROWS] = '{2, 0, 1};

  localparam word_t WORD_MAX   = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN   = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam acc_t  ROUND_HALF = acc_t'(1) <<< (FRACTION_BITS - 1);

  function automatic word_t sat_word(acc_t a);
    word_t r;
    if (a > acc_t'(WORD_MAX)) begin
      r = WORD_MAX;
    end else if (a < acc_t'(WORD_MIN)) begin
      r = WORD_MIN;
    end else begin
      r = a[WORD_BITS-1:0];
    end
    return r;
  endfunction

  function automatic word_t round_sat(acc_t a);
    acc_t r;
    r = (a + ROUND_HALF) >>> FRACTION_BITS;
    return sat_word(r);
  endfunction

endpackage

// File: design/su3_matrix_reunitarize.sv
// ============================================================================
// su3_matrix_reunitarize
// Each matrix leaves the three-beat output serialiser as column beats; the
// pipeline behind it takes a new item in any cycle that in_stall is low,
// and stalls while a finished matrix waits for the serialiser to empty.
// Reset clears the valid bits and the column index; the block accepts
// input straight away.
// ============================================================================
`timescale 1ns / 1ps

module su3_matrix_reunitarize (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  su3r_pkg::word_t first_col_row0_re,
  input  su3r_pkg::word_t first_col_row0_im,
  input  su3r_pkg::word_t first_col_row1_re,
  input  su3r_pkg::word_t first_col_row1_im,
  input  su3r_pkg::word_t first_col_row2_re,
  input  su3r_pkg::word_t first_col_row2_im,
  input  su3r_pkg::word_t second_col_row0_re,
  input  su3r_pkg::word_t second_col_row0_im,
  input  su3r_pkg::word_t second_col_row1_re,
  input  su3r_pkg::word_t second_col_row1_im,
  input  su3r_pkg::word_t second_col_row2_re,
  input  su3r_pkg::word_t second_col_row2_im,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      column_index,
  output su3r_pkg::word_t out_row0_re,
  output su3r_pkg::word_t out_row0_im,
  output su3r_pkg::word_t out_row1_re,
  output su3r_pkg::word_t out_row1_im,
  output su3r_pkg::word_t out_row2_re,
  output su3r_pkg::word_t out_row2_im,
  output logic            last_column,
  output logic            degenerate
);
  import su3r_pkg::*;

  logic        en;
  logic        s0_valid;
  col_t        s0_u;
  col_t        s0_v;
  col_t        un_n;
  norm_flags_t fl_u;
  col_t        v_dly [NORM_LAT];

  logic        p1_valid, p2_valid, p3_valid, p4_valid;
  logic        p1_zu, p2_zu, p3_zu, p4_zu;
  col_t        p1_un, p2_un, p3_un, p4_un;
  col_t        p1_v, p2_v, p3_v;
  prod_t       pp [ROWS][4];
  prod_t       qp [ROWS][4];
  word_t       p2_tr, p2_ti;
  word_t       tr_next, ti_next;
  col_t        v2_next;
  col_t        p4_v2;

  col_t        vn_n;
  norm_flags_t fl_v;
  col_t        un_dly [NORM_LAT];
  logic [NORM_LAT-1:0] zu_dly;

  logic        c1_valid, c2_valid;
  logic        c1_deg, c2_deg;
  col_t        c1_un, c1_vn, c2_un, c2_vn, c2_w;
  prod_t       cp [ROWS][8];
  col_t        w_next;

  logic        ser_deg;
  col_t        ser_u, ser_v, ser_w;
  col_idx_t    idx, idx_next;
  col_t        sel;
  logic        out_take;

  assign out_take = out_valid && !out_stall;
  assign en       = !c2_valid || !out_valid || (out_take && idx == COL_W);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
      p4_valid <= 1'b0;
      c1_valid <= 1'b0;
      c2_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_valid;
      p1_valid <= fl_u.valid;
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
      p4_valid <= p3_valid;
      c1_valid <= fl_v.valid;
      c2_valid <= c1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_u <= '{first_col_row0_re, first_col_row0_im, first_col_row1_re,
                first_col_row1_im, first_col_row2_re, first_col_row2_im};
      s0_v <= '{second_col_row0_re, second_col_row0_im, second_col_row1_re,
                second_col_row1_im, second_col_row2_re, second_col_row2_im};
    end
  end

  su3r_normalize u_norm_u (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s0_valid),
    .x        (s0_u),
    .y        (un_n),
    .flags    (fl_u)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      v_dly[0] <= s0_v;
      for (int k = 1; k < NORM_LAT; k++) v_dly[k] <= v_dly[k-1];
    end
  end

  always_comb begin
    acc_t sr;
    acc_t si;
    sr = '0;
    si = '0;
    for (int i = 0; i < ROWS; i++) begin
      sr = sr + acc_t'(pp[i][0]) + acc_t'(pp[i][1]);
      si = si + acc_t'(pp[i][2]) - acc_t'(pp[i][3]);
    end
    tr_next = round_sat(sr);
    ti_next = round_sat(si);
  end

  always_comb begin
    for (int i = 0; i < ROWS; i++) begin
      v2_next[2*i]   = round_sat((acc_t'(p3_v[2*i]) <<< FRACTION_BITS)
                                 - (acc_t'(qp[i][0]) - acc_t'(qp[i][1])));
      v2_next[2*i+1] = round_sat((acc_t'(p3_v[2*i+1]) <<< FRACTION_BITS)
                                 - (acc_t'(qp[i][2]) + acc_t'(qp[i][3])));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < ROWS; i++) begin
        pp[i][0] <= un_n[2*i]   * v_dly[NORM_LAT-1][2*i];
        pp[i][1] <= un_n[2*i+1] * v_dly[NORM_LAT-1][2*i+1];
        pp[i][2] <= un_n[2*i]   * v_dly[NORM_LAT-1][2*i+1];
        pp[i][3] <= un_n[2*i+1] * v_dly[NORM_LAT-1][2*i];
      end
      p1_un <= un_n;
      p1_v  <= v_dly[NORM_LAT-1];
      p1_zu <= fl_u.zero;

      p2_tr <= tr_next;
      p2_ti <= ti_next;
      p2_un <= p1_un;
      p2_v  <= p1_v;
      p2_zu <= p1_zu;

      for (int i = 0; i < ROWS; i++) begin
        qp[i][0] <= p2_tr * p2_un[2*i];
        qp[i][1] <= p2_ti * p2_un[2*i+1];
        qp[i][2] <= p2_tr * p2_un[2*i+1];
        qp[i][3] <= p2_ti * p2_un[2*i];
      end
      p3_un <= p2_un;
      p3_v  <= p2_v;
      p3_zu <= p2_zu;

      p4_v2 <= v2_next;
      p4_un <= p3_un;
      p4_zu <= p3_zu;
    end
  end

  su3r_normalize u_norm_v (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (p4_valid),
    .x        (p4_v2),
    .y        (vn_n),
    .flags    (fl_v)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      un_dly[0] <= p4_un;
      zu_dly[0] <= p4_zu;
      for (int k = 1; k < NORM_LAT; k++) begin
        un_dly[k] <= un_dly[k-1];
        zu_dly[k] <= zu_dly[k-1];
      end
    end
  end

  always_comb begin
    acc_t r1, r2, i1, i2;
    for (int k = 0; k < ROWS; k++) begin
      r1 = acc_t'(cp[k][0]) - acc_t'(cp[k][1]);
      i1 = acc_t'(cp[k][2]) + acc_t'(cp[k][3]);
      r2 = acc_t'(cp[k][4]) - acc_t'(cp[k][5]);
      i2 = acc_t'(cp[k][6]) + acc_t'(cp[k][7]);
      w_next[2*k]   = round_sat(r1 - r2);
      w_next[2*k+1] = round_sat(i2 - i1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < ROWS; k++) begin
        cp[k][0] <= un_dly[NORM_LAT-1][2*CROSS_A[k]]   * vn_n[2*CROSS_B[k]];
        cp[k][1] <= un_dly[NORM_LAT-1][2*CROSS_A[k]+1] * vn_n[2*CROSS_B[k]+1];
        cp[k][2] <= un_dly[NORM_LAT-1][2*CROSS_A[k]]   * vn_n[2*CROSS_B[k]+1];
        cp[k][3] <= un_dly[NORM_LAT-1][2*CROSS_A[k]+1] * vn_n[2*CROSS_B[k]];
        cp[k][4] <= un_dly[NORM_LAT-1][2*CROSS_B[k]]   * vn_n[2*CROSS_A[k]];
        cp[k][5] <= un_dly[NORM_LAT-1][2*CROSS_B[k]+1] * vn_n[2*CROSS_A[k]+1];
        cp[k][6] <= un_dly[NORM_LAT-1][2*CROSS_B[k]]   * vn_n[2*CROSS_A[k]+1];
        cp[k][7] <= un_dly[NORM_LAT-1][2*CROSS_B[k]+1] * vn_n[2*CROSS_A[k]];
      end
      c1_un  <= un_dly[NORM_LAT-1];
      c1_vn  <= vn_n;
      c1_deg <= zu_dly[NORM_LAT-1] | fl_v.zero;

      c2_w   <= w_next;
      c2_un  <= c1_un;
      c2_vn  <= c1_vn;
      c2_deg <= c1_deg;
    end
  end

  // The serialiser loads a matrix when empty or as its current last beat leaves.
  always_comb begin
    unique case (idx)
      COL_U:   idx_next = COL_V;
      COL_V:   idx_next = COL_W;
      COL_W:   idx_next = COL_U;
      default: idx_next = COL_U;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= COL_U;
    end else if (en && c2_valid) begin
      out_valid <= 1'b1;
      idx       <= COL_U;
    end else if (out_take) begin
      out_valid <= (idx != COL_W);
      idx       <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en && c2_valid) begin
      ser_deg <= c2_deg;
      for (int i = 0; i < PARTS; i++) begin
        ser_u[i] <= c2_deg ? '0 : c2_un[i];
        ser_v[i] <= c2_deg ? '0 : c2_vn[i];
        ser_w[i] <= c2_deg ? '0 : c2_w[i];
      end
    end
  end

  always_comb begin
    unique case (idx)
      COL_U:   sel = ser_u;
      COL_V:   sel = ser_v;
      COL_W:   sel = ser_w;
      default: sel = ser_u;
    endcase
  end

  assign column_index = idx;
  assign out_row0_re  = sel[0];
  assign out_row0_im  = sel[1];
  assign out_row1_re  = sel[2];
  assign out_row1_im  = sel[3];
  assign out_row2_re  = sel[4];
  assign out_row2_im  = sel[5];
  assign last_column  = (idx == COL_W);
  assign degenerate   = ser_deg;

  assert property (@(posedge clk) disable iff (rst) in_stall |-> c2_valid)
    else $error("Input stalled while the pipeline tail is empty.");

  assert property (@(posedge clk) disable iff (rst)
                   (out_take && !last_column) |=> out_valid)
    else $error("Matrix ended before its third column beat.");

  assert property (@(posedge clk) disable iff (rst)
                   (out_take && last_column) |=> (!out_valid || column_index == COL_U))
    else $error("New matrix did not start on its first column.");

  assert property (@(posedge clk) disable iff (rst)
                   (out_valid && degenerate) |->
                   (out_row0_re == '0 && out_row0_im == '0 && out_row1_re == '0 &&
                    out_row1_im == '0 && out_row2_re == '0 && out_row2_im == '0))
    else $error("Degenerate matrix carries non-zero entries.");

  assert property (@(posedge clk) disable iff (rst)
                   out_valid |-> (column_index != 2'd3))
    else $error("Column index out of range.");

endmodule

// File: design/su3r_isqrt_pipe.sv
// ============================================================================
// su3r_isqrt_pipe
// Pipelined floor square root, one result bit per stage.
// ============================================================================
`timescale 1ns / 1ps

module su3r_isqrt_pipe (
  input  logic           clk,
  input  logic           en,
  input  su3r_pkg::sum_t  radicand,
  output su3r_pkg::root_t root
);
  import su3r_pkg::*;

  typedef struct packed {
    logic [RAD_BITS-1:0] rad;
    logic [REM_BITS-1:0] rem;
    root_t               res;
  } sq_stage_t;

  function automatic sq_stage_t sqrt_step(sq_stage_t s);
    sq_stage_t           o;
    logic [REM_BITS-1:0] r;
    logic [REM_BITS-1:0] t;
    r = {s.rem[REM_BITS-3:0], s.rad[RAD_BITS-1 -: 2]};
    t = {{(REM_BITS-ROOT_BITS-2){1'b0}}, s.res, 2'b01};
    o.rad = {s.rad[RAD_BITS-3:0], 2'b00};
    if (r >= t) begin
      o.rem = r - t;
      o.res = {s.res[ROOT_BITS-2:0], 1'b1};
    end else begin
      o.rem = r;
      o.res = {s.res[ROOT_BITS-2:0], 1'b0};
    end
    return o;
  endfunction

  sq_stage_t stg_in;
  sq_stage_t pipe [ROOT_BITS];

  always_comb begin
    stg_in.rad = {{(RAD_BITS-SUM_BITS){1'b0}}, radicand};
    stg_in.rem = '0;
    stg_in.res = '0;
  end

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_step
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) pipe[k] <= sqrt_step(stg_in);
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) pipe[k] <= sqrt_step(pipe[k-1]);
      end
    end
  end

  assign root = pipe[ROOT_BITS-1].res;

endmodule

// File: design/su3r_div_pipe.sv
// ============================================================================
// su3r_div_pipe
// Pipelined restoring divider, six lanes over one shared divisor, one
// quotient bit per stage.
// ============================================================================
`timescale 1ns / 1ps

module su3r_div_pipe (
  input  logic           clk,
  input  logic           en,
  input  su3r_pkg::num_t num [su3r_pkg::PARTS],
  input  su3r_pkg::den_t den,
  output su3r_pkg::quo_t quo [su3r_pkg::PARTS]
);
  import su3r_pkg::*;

  typedef struct packed {
    den_t rem;
    quo_t lq;
  } div_lane_t;

  function automatic div_lane_t div_step(div_lane_t s, den_t d);
    div_lane_t         o;
    logic [DEN_BITS:0] r;
    r = {s.rem, s.lq[QUO_BITS-1]};
    if (r >= {1'b0, d}) begin
      o.rem = den_t'(r - {1'b0, d});
      o.lq  = {s.lq[QUO_BITS-2:0], 1'b1};
    end else begin
      o.rem = r[DEN_BITS-1:0];
      o.lq  = {s.lq[QUO_BITS-2:0], 1'b0};
    end
    return o;
  endfunction

  div_lane_t lane_in [PARTS];
  div_lane_t lane [QUO_BITS][PARTS];
  den_t      den_p [QUO_BITS];

  always_comb begin
    for (int i = 0; i < PARTS; i++) begin
      lane_in[i].rem = den_t'(num[i][NUM_BITS-1:QUO_BITS]);
      lane_in[i].lq  = num[i][QUO_BITS-1:0];
    end
  end

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_step
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          den_p[k] <= den;
          for (int i = 0; i < PARTS; i++) lane[k][i] <= div_step(lane_in[i], den);
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) begin
          den_p[k] <= den_p[k-1];
          for (int i = 0; i < PARTS; i++) lane[k][i] <= div_step(lane[k-1][i], den_p[k-1]);
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < PARTS; i++) quo[i] = lane[QUO_BITS-1][i].lq;
  end

endmodule

// File: design/su3r_normalize.sv
// ============================================================================
// su3r_normalize
// Scales one complex column to unit length: squares, sum, square root and
// six rounded divisions, with a flag for a zero norm.
// ============================================================================
`timescale 1ns / 1ps

module su3r_normalize (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  su3r_pkg::col_t        x,
  output su3r_pkg::col_t        y,
  output su3r_pkg::norm_flags_t flags
);
  import su3r_pkg::*;

  logic [NORM_LAT-1:0]  vld;
  prod_t                sq [PARTS];
  col_t                 x1;
  col_t                 x2;
  sum_t                 s2;
  sum_t                 s_next;
  col_t                 x_dly [ROOT_BITS];
  root_t                root;
  logic [WORD_BITS-1:0] mag [PARTS];
  num_t                 num3 [PARTS];
  den_t                 den3;
  logic [PARTS-1:0]     neg3;
  logic                 zero3;
  logic [PARTS-1:0]     neg_dly [QUO_BITS];
  logic [QUO_BITS-1:0]  zero_dly;
  quo_t                 quo [PARTS];
  col_t                 y_next;
  col_t                 y_r;
  logic                 zero_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NORM_LAT-2:0], in_valid};
    end
  end

  always_comb begin
    s_next = '0;
    for (int i = 0; i < PARTS; i++) s_next = s_next + sum_t'(sq[i]);
  end

  always_comb begin
    for (int i = 0; i < PARTS; i++) begin
      mag[i] = x_dly[ROOT_BITS-1][i][WORD_BITS-1] ? -x_dly[ROOT_BITS-1][i]
                                                   : x_dly[ROOT_BITS-1][i];
    end
  end

  always_comb begin
    acc_t qa;
    for (int i = 0; i < PARTS; i++) begin
      qa = acc_t'(quo[i]);
      y_next[i] = zero_dly[QUO_BITS-1] ? '0
                  : sat_word(neg_dly[QUO_BITS-1][i] ? -qa : qa);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < PARTS; i++) sq[i] <= x[i] * x[i];
      x1 <= x;
      s2 <= s_next;
      x2 <= x1;
      x_dly[0] <= x2;
      for (int k = 1; k < ROOT_BITS; k++) x_dly[k] <= x_dly[k-1];
      for (int i = 0; i < PARTS; i++) begin
        num3[i] <= (num_t'(mag[i]) << (FRACTION_BITS + 1)) + num_t'(root);
        neg3[i] <= x_dly[ROOT_BITS-1][i][WORD_BITS-1];
      end
      den3  <= {root, 1'b0};
      zero3 <= (root == '0);
      neg_dly[0]  <= neg3;
      zero_dly[0] <= zero3;
      for (int k = 1; k < QUO_BITS; k++) begin
        neg_dly[k]  <= neg_dly[k-1];
        zero_dly[k] <= zero_dly[k-1];
      end
      y_r    <= y_next;
      zero_r <= zero_dly[QUO_BITS-1];
    end
  end

  su3r_isqrt_pipe u_isqrt (
    .clk      (clk),
    .en       (en),
    .radicand (s2),
    .root     (root)
  );

  su3r_div_pipe u_div (
    .clk (clk),
    .en  (en),
    .num (num3),
    .den (den3),
    .quo (quo)
  );

  assign y           = y_r;
  assign flags.valid = vld[NORM_LAT-1];
  assign flags.zero  = zero_r;

endmodule
